// ----- rtl/srg_pkg.sv -----
// Package for the subtractive random generator: constants, datapath operation
// codes and the command/status structs shared by controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package srg_pkg;

  localparam int unsigned ValueW = 30;
  localparam int unsigned SeedW  = 29;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned TableLen = 55;

  localparam logic [ValueW-1:0] Modulus   = 30'd1000000000;
  localparam logic [SeedW-1:0]  SeedLimit = 29'd161803398;
  localparam logic [AddrW-1:0]  FillStride  = 6'd21;
  localparam logic [AddrW-1:0]  MixStart    = 6'd31;
  localparam logic [AddrW-1:0]  SecondStart = 6'd31;
  localparam logic [AddrW-1:0]  LastAddr    = 6'(TableLen - 1);
  localparam logic [AddrW-1:0]  FillLast    = 6'(TableLen - 2);
  localparam logic [AddrW:0]    IndexWrap   = 7'd56;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEED_LOAD,
    OP_FILL_HEAD,
    OP_FILL_STEP,
    OP_MIX_READ,
    OP_MIX_WRITE,
    OP_DRAW_READ,
    OP_DRAW_WRITE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
    logic pass_last;
  } status_t;

  // Difference of two residues, kept in 0 .. Modulus-1.
  function automatic logic [ValueW-1:0] sub_mod(input logic [ValueW-1:0] a,
                                                input logic [ValueW-1:0] b);
    logic [ValueW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[ValueW]) begin
      d = d + {1'b0, Modulus};
    end
    return d[ValueW-1:0];
  endfunction

endpackage

// ----- rtl/subtractive_random_generator.sv -----
// Subtractive random generator (lagged subtractive scheme, modulus 10^9).
// Draw: table read, then subtract and write back through the single write port,
// then output load; no new item is taken until the result is registered.
// Seed: 1 load, 55 fill writes, 4 x 55 read/write mixing steps, 1 output load;
// no item is taken meanwhile.
// Reset (async, active low): table reads as all zeros, both indices zero.
`timescale 1ns / 1ps

// The top level joins the controller, which owns the handshakes and the
// sequence of operations, with the datapath, which holds the 55-word lag
// table, the loop counters and the output register. An item whose cmd is 0
// reseeds the table and returns 0; an item whose cmd is 1 returns the next
// drawn number. A new item may be accepted while the previous result still
// waits in the output register; the controller only holds its own result
// back until that register is free.
module subtractive_random_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [srg_pkg::SeedW-1:0]   seed_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [srg_pkg::ValueW-1:0]  value_o
);

  // Operation for the datapath this cycle, and loop-end flags coming back.
  srg_pkg::cmd_t    cmd;
  srg_pkg::status_t status;

  srg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The seed is sampled by the datapath only in the accepting cycle of a
  // seed item, so it is wired straight through from the input port.
  srg_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .seed_i   (seed_i),
    .status_o (status),
    .value_o  (value_o)
  );

endmodule

// ----- rtl/srg_datapath.sv -----
// Datapath of the subtractive random generator: lag table memory, loop
// counters, index registers, the modular subtractor and the output register.
// Depends on srg_pkg.
`timescale 1ns / 1ps

module srg_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srg_pkg::cmd_t               cmd_i,
  input  logic [srg_pkg::SeedW-1:0]   seed_i,
  output srg_pkg::status_t            status_o,
  output logic [srg_pkg::ValueW-1:0]  value_o
);

  logic [srg_pkg::ValueW-1:0] mem_q [srg_pkg::TableLen];
  logic [srg_pkg::TableLen-1:0] vld_q;

  logic [srg_pkg::ValueW-1:0] cur_q, cur_d;
  logic [srg_pkg::ValueW-1:0] prev_q, prev_d;
  logic [srg_pkg::ValueW-1:0] rd_a_q, rd_b_q;
  logic [srg_pkg::ValueW-1:0] res_q, res_d;
  logic [srg_pkg::ValueW-1:0] value_q;
  logic [srg_pkg::AddrW-1:0]  pos_q, pos_d;
  logic [srg_pkg::AddrW-1:0]  step_q, step_d;
  logic [srg_pkg::AddrW-1:0]  mixb_q, mixb_d;
  logic [1:0]                 pass_q, pass_d;
  logic [srg_pkg::AddrW-1:0]  first_q, first_d;
  logic [srg_pkg::AddrW-1:0]  second_q, second_d;

  logic [srg_pkg::SeedW-1:0]  mag;
  logic [srg_pkg::AddrW:0]    first_inc, second_inc;
  logic [srg_pkg::AddrW-1:0]  first_adv, second_adv;
  logic [srg_pkg::AddrW:0]    pos_sum;
  logic [srg_pkg::ValueW-1:0] diff;

  logic                       we, re;
  logic [srg_pkg::AddrW-1:0]  waddr, raddr_a, raddr_b;
  logic [srg_pkg::ValueW-1:0] wdata;

  assign mag = seed_i[srg_pkg::SeedW-1] ? (~seed_i + 1'b1) : seed_i;

  assign first_inc  = {1'b0, first_q} + 1'b1;
  assign second_inc = {1'b0, second_q} + 1'b1;
  assign first_adv  = (first_inc >= srg_pkg::IndexWrap) ? 6'd1 : first_inc[srg_pkg::AddrW-1:0];
  assign second_adv = (second_inc >= srg_pkg::IndexWrap) ? 6'd1 :
                      second_inc[srg_pkg::AddrW-1:0];

  assign pos_sum = {1'b0, pos_q} + {1'b0, srg_pkg::FillStride};
  assign diff    = srg_pkg::sub_mod(rd_a_q, rd_b_q);

  always_comb begin
    cur_d    = cur_q;
    prev_d   = prev_q;
    res_d    = res_q;
    pos_d    = pos_q;
    step_d   = step_q;
    mixb_d   = mixb_q;
    pass_d   = pass_q;
    first_d  = first_q;
    second_d = second_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = step_q;
    wdata    = diff;
    raddr_a  = step_q;
    raddr_b  = mixb_q;
    case (cmd_i.op)
      srg_pkg::OP_SEED_LOAD: begin
        if (mag > srg_pkg::SeedLimit) begin
          cur_d = '0;
        end else begin
          cur_d = srg_pkg::ValueW'(srg_pkg::SeedLimit - mag);
        end
        prev_d   = 30'd1;
        pos_d    = srg_pkg::FillStride;
        step_d   = '0;
        res_d    = '0;
        first_d  = '0;
        second_d = srg_pkg::SecondStart;
      end
      srg_pkg::OP_FILL_HEAD: begin
        we    = 1'b1;
        waddr = srg_pkg::LastAddr;
        wdata = cur_q;
      end
      srg_pkg::OP_FILL_STEP: begin
        we     = 1'b1;
        waddr  = pos_q - 1'b1;
        wdata  = prev_q;
        prev_d = srg_pkg::sub_mod(cur_q, prev_q);
        cur_d  = prev_q;
        pos_d  = (pos_sum >= 7'(srg_pkg::TableLen)) ?
                 srg_pkg::AddrW'(pos_sum - 7'(srg_pkg::TableLen)) :
                 pos_sum[srg_pkg::AddrW-1:0];
        if (step_q == srg_pkg::FillLast) begin
          step_d = '0;
          mixb_d = srg_pkg::MixStart;
          pass_d = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      srg_pkg::OP_MIX_READ: begin
        re = 1'b1;
      end
      srg_pkg::OP_MIX_WRITE: begin
        we     = 1'b1;
        mixb_d = (mixb_q == srg_pkg::LastAddr) ? '0 : mixb_q + 1'b1;
        if (step_q == srg_pkg::LastAddr) begin
          step_d = '0;
          pass_d = pass_q + 1'b1;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      srg_pkg::OP_DRAW_READ: begin
        re       = 1'b1;
        raddr_a  = first_adv - 1'b1;
        raddr_b  = second_adv - 1'b1;
        first_d  = first_adv;
        second_d = second_adv;
      end
      srg_pkg::OP_DRAW_WRITE: begin
        we    = 1'b1;
        waddr = first_q - 1'b1;
        res_d = diff;
      end
      default: begin
      end
    endcase
  end

  // Table storage; an entry never written since reset reads as zero.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_a_q <= vld_q[raddr_a] ? mem_q[raddr_a] : '0;
      rd_b_q <= vld_q[raddr_b] ? mem_q[raddr_b] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      step_q   <= '0;
      mixb_q   <= '0;
      pass_q   <= '0;
      pos_q    <= '0;
    end else begin
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      first_q  <= first_d;
      second_q <= second_d;
      step_q   <= step_d;
      mixb_q   <= mixb_d;
      pass_q   <= pass_d;
      pos_q    <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    res_q  <= res_d;
    if (cmd_i.out_load) begin
      value_q <= res_q;
    end
  end

  assign status_o.fill_last = (step_q == srg_pkg::FillLast);
  assign status_o.mix_last  = (step_q == srg_pkg::LastAddr);
  assign status_o.pass_last = (pass_q == 2'd3);
  assign value_o = value_q;

`ifndef SYNTHESIS
  a_fill_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == srg_pkg::OP_FILL_STEP |-> pos_q != '0 && pos_q <= srg_pkg::LastAddr)
    else $error("fill position outside the table");
  a_draw_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == srg_pkg::OP_DRAW_WRITE |-> first_q != '0 && second_q != '0 &&
      first_q <= 6'd55 && second_q <= 6'd55)
    else $error("draw index outside 1..55");
  a_draw_res_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == srg_pkg::OP_DRAW_WRITE |=> res_q < srg_pkg::Modulus)
    else $error("drawn value not reduced");
`endif

endmodule

// ----- rtl/srg_ctrl.sv -----
// Controller of the subtractive random generator: sequences seeding and
// drawing, drives the input stall and the output valid. Depends on srg_pkg.
`timescale 1ns / 1ps

module srg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             cmd_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  srg_pkg::status_t status_i,
  output srg_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_HEAD,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_WR,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o.op     = srg_pkg::OP_NONE;
    cmd_o.out_load = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_i) begin
            cmd_o.op = srg_pkg::OP_DRAW_READ;
            state_d  = ST_DRAW_WR;
          end else begin
            cmd_o.op = srg_pkg::OP_SEED_LOAD;
            state_d  = ST_FILL_HEAD;
          end
        end
      end
      ST_FILL_HEAD: begin
        cmd_o.op = srg_pkg::OP_FILL_HEAD;
        state_d  = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.op = srg_pkg::OP_FILL_STEP;
        if (status_i.fill_last) begin
          state_d = ST_MIX_RD;
        end
      end
      ST_MIX_RD: begin
        cmd_o.op = srg_pkg::OP_MIX_READ;
        state_d  = ST_MIX_WR;
      end
      ST_MIX_WR: begin
        cmd_o.op = srg_pkg::OP_MIX_WRITE;
        state_d  = (status_i.mix_last && status_i.pass_last) ? ST_DONE : ST_MIX_RD;
      end
      ST_DRAW_WR: begin
        cmd_o.op = srg_pkg::OP_DRAW_WRITE;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted but controller stayed idle");
  a_done_loads_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished item not moved to the output register");
  a_mix_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MIX_WR && status_i.mix_last && status_i.pass_last |=> state_q == ST_DONE)
    else $error("mixing did not end after the fourth pass");
`endif

endmodule
